// ===== rtl/vgts_pkg.sv =====
`default_nettype none

package vgts_pkg;

  // fixed field widths
  localparam int POS_W    = 17;
  localparam int SIZE_W   = 7;
  localparam int FRAC_W   = 16;
  localparam int SCALED_W = POS_W + SIZE_W;
  localparam int COORD_W  = SCALED_W - FRAC_W;
  localparam int AREA_W   = 2 * SIZE_W;
  localparam int IDX_W    = 24;
  localparam int WADDR_W  = 18;
  localparam int WVAL_W   = 16;
  localparam int DOUT_W   = 16;

  // corner weights: per-axis weight up to 1.0, product up to 2^48
  localparam int WGT_W     = FRAC_W + 1;
  localparam int WXY_W     = 2 * FRAC_W + 1;
  localparam int W_W       = 3 * FRAC_W + 1;
  localparam int WLO_W     = 24;
  localparam int WHI_W     = W_W - WLO_W;
  localparam int SUM_SHIFT = 3 * FRAC_W;

  localparam logic [WGT_W-1:0] FRAC_ONE = WGT_W'(1) << FRAC_W;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  localparam logic [1:0] REG_INTERP = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_NEAREST = 2'd1,
    CMD_TRILIN  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [SIZE_W-1:0] sx;
    logic [SIZE_W-1:0] sy;
    logic [SIZE_W-1:0] sz;
    logic              interp;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [WADDR_W-1:0] waddr;
    logic [WVAL_W-1:0]  wdata;
    logic [IDX_W-1:0]   base;
    logic [SIZE_W-1:0]  stride_y;
    logic [AREA_W-1:0]  stride_z;
    logic [1:0]         vx;
    logic [1:0]         vy;
    logic [1:0]         vz;
    logic [FRAC_W-1:0]  fx;
    logic [FRAC_W-1:0]  fy;
    logic [FRAC_W-1:0]  fz;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/vgts_front.sv =====
`default_nettype none

module vgts_front #(
  parameter int GRID_DEPTH = 262144,
  parameter int MAX_DIM    = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire vgts_pkg::cfg_t                cfg,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          in_op,
  input  wire logic [vgts_pkg::WADDR_W-1:0]  in_write_addr,
  input  wire logic [vgts_pkg::WVAL_W-1:0]   in_write_value,
  input  wire logic [vgts_pkg::POS_W-1:0]    in_pos_x,
  input  wire logic [vgts_pkg::POS_W-1:0]    in_pos_y,
  input  wire logic [vgts_pkg::POS_W-1:0]    in_pos_z,
  output logic                               q_push,
  output vgts_pkg::cmd_t                     q_cmd,
  input  wire logic                          q_full
);

  localparam int LIM_W = vgts_pkg::IDX_W + 1;
  localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(GRID_DEPTH);

  function automatic logic [vgts_pkg::SIZE_W-1:0] eff_size(
    input logic [vgts_pkg::SIZE_W-1:0] s
  );
    if (int'(s) > MAX_DIM) begin
      return vgts_pkg::SIZE_W'(MAX_DIM);
    end
    return s;
  endfunction

  logic [vgts_pkg::SIZE_W-1:0]   sx_e, sy_e, sz_e;
  logic                          accept, s1_adv, drop, wr_ok;

  logic                          s1_vld_r, s1_vld_nxt;
  logic                          s1_op_r;
  logic [vgts_pkg::WADDR_W-1:0]  s1_waddr_r;
  logic [vgts_pkg::WVAL_W-1:0]   s1_wdata_r;
  logic [vgts_pkg::SCALED_W-1:0] s1_px_r, s1_py_r, s1_pz_r;
  logic [vgts_pkg::AREA_W-1:0]   s1_sxy_r;

  logic [vgts_pkg::COORD_W-1:0]  ix, iy, iz;
  logic [vgts_pkg::IDX_W-1:0]    base;

  assign sx_e = eff_size(cfg.sx);
  assign sy_e = eff_size(cfg.sy);
  assign sz_e = eff_size(cfg.sz);

  assign ix = s1_px_r[vgts_pkg::SCALED_W-1:vgts_pkg::FRAC_W];
  assign iy = s1_py_r[vgts_pkg::SCALED_W-1:vgts_pkg::FRAC_W];
  assign iz = s1_pz_r[vgts_pkg::SCALED_W-1:vgts_pkg::FRAC_W];

  assign wr_ok  = LIM_W'(s1_waddr_r) < DEPTH_LIM;
  // writes past the end of the store are dropped here, never queued
  assign drop   = (s1_op_r == vgts_pkg::OP_WRITE) && !wr_ok;
  assign s1_adv = s1_vld_r && (drop || !q_full);
  assign q_push = s1_vld_r && !drop && !q_full;
  assign full   = s1_vld_r && !s1_adv;
  assign accept = push && !full;

  assign base = vgts_pkg::IDX_W'(ix)
              + vgts_pkg::IDX_W'(iy) * vgts_pkg::IDX_W'(sx_e)
              + vgts_pkg::IDX_W'(iz) * vgts_pkg::IDX_W'(s1_sxy_r);

  always_comb begin
    q_cmd          = '0;
    q_cmd.waddr    = s1_waddr_r;
    q_cmd.wdata    = s1_wdata_r;
    q_cmd.base     = base;
    q_cmd.stride_y = sx_e;
    q_cmd.stride_z = s1_sxy_r;
    q_cmd.vx[0]    = ix < vgts_pkg::COORD_W'(sx_e);
    q_cmd.vx[1]    = (ix + vgts_pkg::COORD_W'(1)) < vgts_pkg::COORD_W'(sx_e);
    q_cmd.vy[0]    = iy < vgts_pkg::COORD_W'(sy_e);
    q_cmd.vy[1]    = (iy + vgts_pkg::COORD_W'(1)) < vgts_pkg::COORD_W'(sy_e);
    q_cmd.vz[0]    = iz < vgts_pkg::COORD_W'(sz_e);
    q_cmd.vz[1]    = (iz + vgts_pkg::COORD_W'(1)) < vgts_pkg::COORD_W'(sz_e);
    if (s1_op_r == vgts_pkg::OP_WRITE) begin
      q_cmd.kind = vgts_pkg::CMD_WRITE;
    end else if (cfg.interp) begin
      q_cmd.kind = vgts_pkg::CMD_TRILIN;
      q_cmd.fx   = s1_px_r[vgts_pkg::FRAC_W-1:0];
      q_cmd.fy   = s1_py_r[vgts_pkg::FRAC_W-1:0];
      q_cmd.fz   = s1_pz_r[vgts_pkg::FRAC_W-1:0];
    end else begin
      // zero fractions make corner 000 weigh exactly 1.0
      q_cmd.kind = vgts_pkg::CMD_NEAREST;
    end
  end

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= in_op;
      s1_waddr_r <= in_write_addr;
      s1_wdata_r <= in_write_value;
      s1_px_r    <= vgts_pkg::SCALED_W'(in_pos_x) * vgts_pkg::SCALED_W'(sx_e);
      s1_py_r    <= vgts_pkg::SCALED_W'(in_pos_y) * vgts_pkg::SCALED_W'(sy_e);
      s1_pz_r    <= vgts_pkg::SCALED_W'(in_pos_z) * vgts_pkg::SCALED_W'(sz_e);
      s1_sxy_r   <= vgts_pkg::AREA_W'(sx_e) * vgts_pkg::AREA_W'(sy_e);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vgts_cmdq.sv =====
`default_nettype none

module vgts_cmdq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire vgts_pkg::cmd_t cmd_in,
  output logic                full,
  input  wire logic           pop,
  output vgts_pkg::cmd_t      head,
  output logic                valid
);

  vgts_pkg::cmd_t ent_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push_ok, pop_ok;

  assign full    = cnt_r == 2'd2;
  assign valid   = cnt_r != 2'd0;
  assign head    = ent_r[rp_r];
  assign push_ok = push && !full;
  assign pop_ok  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) begin
        wp_r <= ~wp_r;
      end
      if (pop_ok) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push_ok) - 2'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      ent_r[wp_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vgts_back.sv =====
`default_nettype none

module vgts_back #(
  parameter int GRID_DEPTH   = 262144,
  parameter int DENSITY_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire vgts_pkg::cmd_t              q_head,
  output logic                             q_pop,
  input  wire logic                        pop,
  output logic                             empty,
  output logic [vgts_pkg::DOUT_W-1:0]      out_density_out
);

  localparam int AW    = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
  localparam int LIM_W = vgts_pkg::IDX_W + 1;
  localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(GRID_DEPTH);
  localparam int ACC_W = vgts_pkg::SUM_SHIFT + DENSITY_BITS;
  localparam int PH_W  = vgts_pkg::WHI_W + DENSITY_BITS;
  localparam int PL_W  = vgts_pkg::WLO_W + DENSITY_BITS;
  localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (vgts_pkg::SUM_SHIFT - 1);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_RUN  = 2'b10
  } bk_state_t;

  typedef struct packed {
    logic vld;
    logic cvalid;
    logic first;
    logic last;
  } stage_ctl_t;

  bk_state_t      state_r, state_nxt;
  vgts_pkg::cmd_t cur_r, cur_nxt;
  logic [2:0]     cnt_r, cnt_nxt;
  logic [1:0]     inflight_r, inflight_nxt;
  logic           start, mem_we, rd_en, issue, last_corner, credit_ok, head_is_wr;

  logic                       dx, dy, dz;
  logic [vgts_pkg::IDX_W-1:0] idx;
  logic                       cvalid;
  logic [vgts_pkg::WGT_W-1:0] wx, wy, wz;

  logic [DENSITY_BITS-1:0] grid_mem [GRID_DEPTH];
  logic [DENSITY_BITS-1:0] rd_r;

  stage_ctl_t                 p1_ctl_r, p2_ctl_r, p3_ctl_r, p4_ctl_r;
  logic [vgts_pkg::WGT_W-1:0] p1_wx_r, p1_wy_r, p1_wz_r, p2_wz_r;
  logic [DENSITY_BITS-1:0]    d1, p2_d_r, p3_d_r;
  logic [vgts_pkg::WXY_W-1:0] p2_wxy_r;
  logic [vgts_pkg::W_W-1:0]   p3_w_r;
  logic [PH_W-1:0]            p4_ph_r;
  logic [PL_W-1:0]            p4_pl_r;
  logic [ACC_W-1:0]           acc_r, acc_nxt;
  logic                       res_push;

  logic [vgts_pkg::DOUT_W-1:0] oq_r [2];
  logic                        oq_wp_r, oq_rp_r;
  logic [1:0]                  oq_cnt_r;
  logic                        oq_pop;

  // ---------------- corner sequencer ----------------
  assign head_is_wr = q_head.kind == vgts_pkg::CMD_WRITE;
  assign last_corner = (cur_r.kind == vgts_pkg::CMD_NEAREST) ? (cnt_r == 3'd0)
                                                             : (cnt_r == 3'd7);
  // every sample started must find a free output slot when it finishes
  assign credit_ok = (3'(oq_cnt_r) + 3'(inflight_r)) < 3'd2;
  assign issue = state_r == BK_RUN;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    start     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (head_is_wr) begin
            mem_we = 1'b1;
            q_pop  = 1'b1;
          end else if (credit_ok) begin
            start = 1'b1;
          end
        end
      end
      BK_RUN: begin
        if (last_corner) begin
          if (q_valid && !head_is_wr && credit_ok) begin
            start = 1'b1;
          end else begin
            state_nxt = BK_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
    if (start) begin
      q_pop     = 1'b1;
      cur_nxt   = q_head;
      cnt_nxt   = 3'd0;
      state_nxt = BK_RUN;
    end
  end

  assign inflight_nxt = inflight_r + 2'(start) - 2'(res_push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      cnt_r      <= 3'd0;
      inflight_r <= 2'd0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      inflight_r <= inflight_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // corner address and per-axis weights; cnt bits are dx, dy, dz
  assign dx = cnt_r[2];
  assign dy = cnt_r[1];
  assign dz = cnt_r[0];

  assign idx = cur_r.base + vgts_pkg::IDX_W'(dx)
             + (dy ? vgts_pkg::IDX_W'(cur_r.stride_y) : '0)
             + (dz ? vgts_pkg::IDX_W'(cur_r.stride_z) : '0);
  assign cvalid = cur_r.vx[dx] && cur_r.vy[dy] && cur_r.vz[dz] &&
                  (LIM_W'(idx) < DEPTH_LIM);
  assign rd_en = issue && cvalid;

  assign wx = dx ? vgts_pkg::WGT_W'(cur_r.fx) : vgts_pkg::FRAC_ONE - vgts_pkg::WGT_W'(cur_r.fx);
  assign wy = dy ? vgts_pkg::WGT_W'(cur_r.fy) : vgts_pkg::FRAC_ONE - vgts_pkg::WGT_W'(cur_r.fy);
  assign wz = dz ? vgts_pkg::WGT_W'(cur_r.fz) : vgts_pkg::FRAC_ONE - vgts_pkg::WGT_W'(cur_r.fz);

  // single-port grid store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[AW'(q_head.waddr)] <= DENSITY_BITS'(q_head.wdata);
    end else if (rd_en) begin
      rd_r <= grid_mem[AW'(idx)];
    end
  end

  // ---------------- blend pipeline ----------------
  assign d1 = p1_ctl_r.cvalid ? rd_r : '0;

  assign acc_nxt = (p4_ctl_r.first ? ROUND : acc_r)
                 + ACC_W'({p4_ph_r, vgts_pkg::WLO_W'(0)})
                 + ACC_W'(p4_pl_r);
  assign res_push = p4_ctl_r.vld && p4_ctl_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_ctl_r <= '0;
      p2_ctl_r <= '0;
      p3_ctl_r <= '0;
      p4_ctl_r <= '0;
    end else begin
      p1_ctl_r.vld    <= issue;
      p1_ctl_r.cvalid <= cvalid;
      p1_ctl_r.first  <= cnt_r == 3'd0;
      p1_ctl_r.last   <= last_corner;
      p2_ctl_r        <= p1_ctl_r;
      p3_ctl_r        <= p2_ctl_r;
      p4_ctl_r        <= p3_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_wx_r  <= wx;
    p1_wy_r  <= wy;
    p1_wz_r  <= wz;
    p2_d_r   <= d1;
    p2_wxy_r <= vgts_pkg::WXY_W'(p1_wx_r) * vgts_pkg::WXY_W'(p1_wy_r);
    p2_wz_r  <= p1_wz_r;
    p3_d_r   <= p2_d_r;
    p3_w_r   <= vgts_pkg::W_W'(p2_wxy_r) * vgts_pkg::W_W'(p2_wz_r);
    p4_ph_r  <= PH_W'(p3_w_r[vgts_pkg::W_W-1:vgts_pkg::WLO_W]) * PH_W'(p3_d_r);
    p4_pl_r  <= PL_W'(p3_w_r[vgts_pkg::WLO_W-1:0]) * PL_W'(p3_d_r);
    if (p4_ctl_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  // ---------------- result queue ----------------
  assign empty           = oq_cnt_r == 2'd0;
  assign out_density_out = oq_r[oq_rp_r];
  assign oq_pop          = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (res_push) begin
        oq_wp_r <= ~oq_wp_r;
      end
      if (oq_pop) begin
        oq_rp_r <= ~oq_rp_r;
      end
      oq_cnt_r <= oq_cnt_r + 2'(res_push) - 2'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq_r[oq_wp_r] <= vgts_pkg::DOUT_W'(acc_nxt[ACC_W-1:vgts_pkg::SUM_SHIFT]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/volume_grid_trilinear_sampler_unit.sv =====
// Volume grid sampler. Write items load one density entry of the grid store;
// sample items return one density, either the voxel at the truncated scaled
// position or the trilinear blend of its eight neighbors (voxels outside the
// grid size read as zero). A front stage scales the position and forms the
// base index, a two-entry command queue decouples it from the back end, and
// the back end walks the corners through the single port of the grid memory,
// one read per cycle, into a five-stage multiply and accumulate pipeline.
// The grid memory port sets the rate: a trilinear sample holds it for all
// eight corners, a nearest sample for its one corner and a write for one
// access, and a sample that starts from an idle back end (for example right
// after a write) first passes through the idle state. A sample starts only
// while the result queue has room for its result. The store is not cleared
// by reset; read only entries that have been written.
`default_nettype none

module volume_grid_trilinear_sampler_unit #(
  parameter int GRID_DEPTH   = 262144,
  parameter int MAX_DIM      = 64,
  parameter int DENSITY_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          in_op,
  input  wire logic [vgts_pkg::WADDR_W-1:0]  in_write_addr,
  input  wire logic [vgts_pkg::WVAL_W-1:0]   in_write_value,
  input  wire logic [vgts_pkg::POS_W-1:0]    in_pos_x,
  input  wire logic [vgts_pkg::POS_W-1:0]    in_pos_y,
  input  wire logic [vgts_pkg::POS_W-1:0]    in_pos_z,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [vgts_pkg::DOUT_W-1:0]        out_density_out,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [vgts_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [vgts_pkg::CFG_DW-1:0]   pwdata,
  output logic [vgts_pkg::CFG_DW-1:0]        prdata,
  output logic                               pready
);

  vgts_pkg::cfg_t cfg_r;
  logic           cfg_wr;
  logic [1:0]     reg_sel;

  logic           q_push, q_full, q_pop, q_valid;
  vgts_pkg::cmd_t q_cmd, q_head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[vgts_pkg::CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sx     <= vgts_pkg::SIZE_RESET;
      cfg_r.sy     <= vgts_pkg::SIZE_RESET;
      cfg_r.sz     <= vgts_pkg::SIZE_RESET;
      cfg_r.interp <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_sel)
        vgts_pkg::REG_SIZE_X: cfg_r.sx     <= pwdata[vgts_pkg::SIZE_W-1:0];
        vgts_pkg::REG_SIZE_Y: cfg_r.sy     <= pwdata[vgts_pkg::SIZE_W-1:0];
        vgts_pkg::REG_SIZE_Z: cfg_r.sz     <= pwdata[vgts_pkg::SIZE_W-1:0];
        vgts_pkg::REG_INTERP: cfg_r.interp <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      vgts_pkg::REG_SIZE_X: prdata = vgts_pkg::CFG_DW'(cfg_r.sx);
      vgts_pkg::REG_SIZE_Y: prdata = vgts_pkg::CFG_DW'(cfg_r.sy);
      vgts_pkg::REG_SIZE_Z: prdata = vgts_pkg::CFG_DW'(cfg_r.sz);
      vgts_pkg::REG_INTERP: prdata = vgts_pkg::CFG_DW'(cfg_r.interp);
      default:              prdata = '0;
    endcase
  end

  vgts_front #(
    .GRID_DEPTH (GRID_DEPTH),
    .MAX_DIM    (MAX_DIM)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .push           (push),
    .full           (full),
    .in_op          (in_op),
    .in_write_addr  (in_write_addr),
    .in_write_value (in_write_value),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .q_push         (q_push),
    .q_cmd          (q_cmd),
    .q_full         (q_full)
  );

  vgts_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .cmd_in (q_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .head   (q_head),
    .valid  (q_valid)
  );

  vgts_back #(
    .GRID_DEPTH   (GRID_DEPTH),
    .DENSITY_BITS (DENSITY_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_density_out (out_density_out)
  );

endmodule

`default_nettype wire

// ===== rtl/vgts_checker.sv =====
`default_nettype none

module vgts_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          push,
  input wire logic                          full,
  input wire logic                          in_op,
  input wire logic                          empty,
  input wire logic                          pop,
  input wire logic [vgts_pkg::DOUT_W-1:0]   out_density_out,
  input wire logic                          psel,
  input wire logic                          penable,
  input wire logic                          pwrite,
  input wire logic [vgts_pkg::CFG_AW-1:0]   paddr,
  input wire logic [vgts_pkg::CFG_DW-1:0]   pwdata,
  input wire logic [vgts_pkg::CFG_DW-1:0]   prdata
);

  // samples accepted whose result has not been taken yet
  logic [3:0] pending_r;
  logic       smp_in, res_out;

  assign smp_in  = push && !full && (in_op == vgts_pkg::OP_SAMPLE);
  assign res_out = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 4'd0;
    end else begin
      pending_r <= pending_r + 4'(smp_in) - 4'(res_out);
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("outputs not idle after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_density_out))
    else $error("waiting result changed or vanished");

  a_result_has_sample: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> pending_r != 4'd0)
    else $error("result without a pending sample");

  a_interp_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && (paddr[3:2] == vgts_pkg::REG_INTERP) |=>
      (paddr[3:2] != vgts_pkg::REG_INTERP) || (prdata[0] == $past(pwdata[0])))
    else $error("interpolation register readback mismatch");

endmodule

bind volume_grid_trilinear_sampler_unit vgts_checker u_vgts_checker (.*);

`default_nettype wire
